// ===== src/cit_pkg.sv =====
// shared constants and codes for the connection id table
`default_nettype none

package cit_pkg;

    localparam int TABLE_DEPTH  = 8;
    localparam int SLOT_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);

    localparam int ID_W         = 16;
    localparam int FUNC_W       = 2;
    localparam int ACTIVE_W     = 4;
    localparam int SLOT_INDEX_W = 3;

    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int REG_INDEX_W  = APB_ADDR_W - 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd2;

    localparam logic [REG_INDEX_W-1:0] REG_ACTIVE_ENTRIES = 1'b0;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

endpackage

`default_nettype wire

// ===== src/cit_req_if.sv =====
// request channel interface: operation and connection id
`default_nettype none

interface cit_req_if
    import cit_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   connection_id;

    modport source (output valid, output func, output connection_id, input ready);
    modport sink   (input valid, input func, input connection_id, output ready);
endinterface

`default_nettype wire

// ===== src/cit_rsp_if.sv =====
// response channel interface: operation outcome
`default_nettype none

interface cit_rsp_if
    import cit_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    success;
    logic                    table_full;
    logic [SLOT_INDEX_W-1:0] slot_index;

    modport source (output valid, output success, output table_full, output slot_index,
                    input ready);
    modport sink   (input valid, input success, input table_full, input slot_index,
                    output ready);
endinterface

`default_nettype wire

// ===== src/connection_id_table.sv =====
// connection id table: top level with slot scan sequencer and id store
//
// usage:
//   req channel (valid/ready) carries func (add, remove, check) and connection_id.
//   rsp channel (valid/ready) returns success, table_full and slot_index.
//   apb port holds active_entries (byte address 0), the number of slots in use.
// timing:
//   one slot is compared per cycle by a single comparator; an item scans
//   n slots, n = min(active_entries, 8), then updates the table in ST_DONE.
//   the result is loaded into the output register as ST_DONE completes;
//   req.ready returns at that same edge, so a new transaction is accepted
//   only once the previous one has left ST_DONE.
//   while a result waits in the output register the next transaction is still
//   accepted and scanned; its update waits until the output register frees up.
// reset:
//   all slot valid marks clear, active_entries returns to 8, no result pending.
//   stored ids are undefined until written and only compared on valid slots.
`default_nettype none

module connection_id_table
    import cit_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    cit_req_if.sink                    req,
    cit_rsp_if.source                  rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t                  state_reg;
    logic [FUNC_W-1:0]       func_reg;
    logic [ID_W-1:0]         id_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic                    hit_found_reg;
    logic [SLOT_W-1:0]       hit_slot_reg;
    logic                    free_found_reg;
    logic [SLOT_W-1:0]       free_slot_reg;
    logic [TABLE_DEPTH-1:0]  slot_valid_reg;
    logic                    rsp_valid_reg;
    logic                    rsp_success_reg;
    logic                    rsp_full_reg;
    logic [SLOT_INDEX_W-1:0] rsp_slot_reg;
    logic [ID_W-1:0]         rd_id_reg;

    logic [ID_W-1:0]         id_store [TABLE_DEPTH];

    logic [ACTIVE_W-1:0]     active_entries;
    logic [CNT_W-1:0]        active_cnt;
    logic [SLOT_W-1:0]       scan_slot;
    logic [SLOT_W-1:0]       rd_slot;
    logic                    scan_valid;
    logic                    id_match;
    logic [CNT_W-1:0]        idx_next;
    logic                    scan_last;
    logic                    done_go;

    logic                    success_next;
    logic                    full_next;
    logic [SLOT_INDEX_W-1:0] slot_next;
    logic                    store_wr;
    logic                    valid_clr;

    cit_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .active_entries (active_entries)
    );

    always_comb
    begin
        if (int'(active_entries) > TABLE_DEPTH)
        begin
            active_cnt = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            active_cnt = CNT_W'(active_entries);
        end
    end

    assign scan_slot  = idx_reg[SLOT_W-1:0];
    assign scan_valid = slot_valid_reg[scan_slot];
    assign id_match   = scan_valid && (rd_id_reg == id_reg);
    assign idx_next   = idx_reg + 1'b1;
    assign scan_last  = (idx_next == active_cnt);
    assign done_go    = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);

    // store is read for the next slot, registered in rd_id_reg ahead of its compare
    assign rd_slot    = (state_reg == ST_IDLE) ? '0 : idx_next[SLOT_W-1:0];

    always_comb
    begin
        success_next = 1'b0;
        full_next    = 1'b0;
        slot_next    = '0;
        store_wr     = 1'b0;
        valid_clr    = 1'b0;
        case (func_reg)
            FUNC_ADD:
            begin
                if (!hit_found_reg)
                begin
                    if (free_found_reg)
                    begin
                        store_wr     = 1'b1;
                        success_next = 1'b1;
                        slot_next    = SLOT_INDEX_W'(free_slot_reg);
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
            end
            FUNC_REMOVE:
            begin
                if (hit_found_reg)
                begin
                    valid_clr    = 1'b1;
                    success_next = 1'b1;
                    slot_next    = SLOT_INDEX_W'(hit_slot_reg);
                end
            end
            FUNC_CHECK:
            begin
                if (hit_found_reg)
                begin
                    success_next = 1'b1;
                    slot_next    = SLOT_INDEX_W'(hit_slot_reg);
                end
            end
            default:
            begin
                success_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            func_reg        <= '0;
            id_reg          <= '0;
            idx_reg         <= '0;
            hit_found_reg   <= 1'b0;
            hit_slot_reg    <= '0;
            free_found_reg  <= 1'b0;
            free_slot_reg   <= '0;
            slot_valid_reg  <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_success_reg <= 1'b0;
            rsp_full_reg    <= 1'b0;
            rsp_slot_reg    <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && !done_go)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        func_reg       <= req.func;
                        id_reg         <= req.connection_id;
                        idx_reg        <= '0;
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= (active_cnt == '0) ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (id_match && !hit_found_reg)
                    begin
                        hit_found_reg <= 1'b1;
                        hit_slot_reg  <= scan_slot;
                    end
                    if (!scan_valid && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_slot_reg  <= scan_slot;
                    end
                    idx_reg <= idx_next;
                    if (scan_last)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (done_go)
                    begin
                        if (store_wr)
                        begin
                            slot_valid_reg[free_slot_reg] <= 1'b1;
                        end
                        if (valid_clr)
                        begin
                            slot_valid_reg[hit_slot_reg] <= 1'b0;
                        end
                        rsp_valid_reg   <= 1'b1;
                        rsp_success_reg <= success_next;
                        rsp_full_reg    <= full_next;
                        rsp_slot_reg    <= slot_next;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_go && store_wr)
        begin
            id_store[free_slot_reg] <= id_reg;
        end
        rd_id_reg <= id_store[rd_slot];
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.success    = rsp_success_reg;
    assign rsp.table_full = rsp_full_reg;
    assign rsp.slot_index = rsp_slot_reg;

endmodule

`default_nettype wire

// ===== src/cit_regs.sv =====
// apb configuration register block
`default_nettype none

module cit_regs
    import cit_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [ACTIVE_W-1:0]   active_entries
);

    logic [ACTIVE_W-1:0]    active_entries_reg;
    logic [REG_INDEX_W-1:0] reg_index;
    logic                   wr_en;

    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready
                       && (reg_index == REG_ACTIVE_ENTRIES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_entries_reg <= ACTIVE_RESET;
        end
        else if (wr_en)
        begin
            active_entries_reg <= pwdata[ACTIVE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_ACTIVE_ENTRIES)
        begin
            prdata = APB_DATA_W'(active_entries_reg);
        end
    end

    assign active_entries = active_entries_reg;

endmodule

`default_nettype wire

// ===== dv/connection_id_table_checker.sv =====
// checker for the connection id table: tracks the table contents and compares every response
`default_nettype none

module connection_id_table_checker
    import cit_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    cit_req_if                         req,
    cit_rsp_if                         rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic                  pready,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    input  wire logic [APB_DATA_W-1:0] prdata,
    output int                         mismatch_count,
    output int                         outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                    success;
        logic                    table_full;
        logic [SLOT_INDEX_W-1:0] slot_index;
    } outcome_t;

    logic [ID_W-1:0]        stored_id [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] slot_busy;
    logic [SLOT_W-1:0]      free_slot;
    logic [ACTIVE_W-1:0]    active_entries;
    outcome_t               outcome_q [$];
    int                     errors;
    int                     rsp_count;

    assign mismatch_count = errors;
    assign outstanding    = outcome_q.size();

    function automatic int scan_limit();
        return (active_entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_entries);
    endfunction

    function automatic int slot_holding(input logic [ID_W-1:0] id);
        for (int i = 0; i < scan_limit(); i++)
        begin
            if (slot_busy[i] && stored_id[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic int lowest_free();
        for (int i = 0; i < scan_limit(); i++)
        begin
            if (!slot_busy[i])
                return i;
        end
        return -1;
    endfunction

    // free position only moves when some active slot is free
    function automatic void refresh_free_slot();
        int slot;
        slot = lowest_free();
        if (slot >= 0)
            free_slot = SLOT_W'(slot);
    endfunction

    function automatic outcome_t apply_request(input logic [FUNC_W-1:0] func,
                                               input logic [ID_W-1:0]   id);
        outcome_t res;
        int       hit;
        int       slot;
        res = '0;
        hit = slot_holding(id);
        case (func)
            FUNC_ADD:
            begin
                if (hit < 0)
                begin
                    slot = lowest_free();
                    if (slot < 0)
                        res.table_full = 1'b1;
                    else
                    begin
                        stored_id[slot] = id;
                        slot_busy[slot] = 1'b1;
                        refresh_free_slot();
                        res.success    = 1'b1;
                        res.slot_index = SLOT_INDEX_W'(slot);
                    end
                end
            end
            FUNC_REMOVE:
            begin
                if (hit >= 0)
                begin
                    slot_busy[hit] = 1'b0;
                    refresh_free_slot();
                    res.success    = 1'b1;
                    res.slot_index = SLOT_INDEX_W'(hit);
                end
            end
            FUNC_CHECK:
            begin
                if (hit >= 0)
                begin
                    res.success    = 1'b1;
                    res.slot_index = SLOT_INDEX_W'(hit);
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            if (errors < REPORT_LIMIT)
                $display("mismatch on %s at response %0d: expected %0d, got %0d",
                         name, rsp_count, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            slot_busy      = '0;
            free_slot      = '0;
            active_entries = ACTIVE_RESET;
            outcome_q.delete();
            errors         = 0;
            rsp_count      = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    if (errors < REPORT_LIMIT)
                        $display("unexpected response: success %0b table_full %0b slot_index %0d",
                                 rsp.success, rsp.table_full, rsp.slot_index);
                    errors++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("success", want.success, rsp.success);
                    check_field("table_full", want.table_full, rsp.table_full);
                    check_field("slot_index", want.slot_index, rsp.slot_index);
                end
                rsp_count++;
            end
            if (req.valid && req.ready)
                outcome_q.push_back(apply_request(req.func, req.connection_id));
            if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_ACTIVE_ENTRIES)
            begin
                if (pwrite)
                    active_entries = pwdata[ACTIVE_W-1:0];
                else
                    check_field("prdata", APB_DATA_W'(active_entries), prdata);
            end
        end
    end

endmodule

`default_nettype wire

// ===== dv/connection_id_table_tb.sv =====
// testbench top for the connection id table: clock, reset, stimulus and verdict
`default_nettype none

module connection_id_table_tb;
    import cit_pkg::*;

    localparam logic [FUNC_W-1:0]      FUNC_UNUSED  = 2'd3;
    localparam logic [REG_INDEX_W-1:0] REG_UNMAPPED = 1'b1;
    localparam logic [APB_ADDR_W-1:0]  ACTIVE_ADDR  = {REG_ACTIVE_ENTRIES, 2'b00};
    localparam logic [APB_ADDR_W-1:0]  UNUSED_ADDR  = {REG_UNMAPPED, 2'b00};
    localparam int                     MAX_WAIT     = 14;
    localparam int                     STALL_LIMIT  = 2000;
    localparam int                     DRAIN_CYCLES = 20;
    localparam int                     POOL_SIZE    = 12;
    localparam int                     PHASES       = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatch_count;
    int                    outstanding;
    int                    quiet_cycles = 0;
    bit                    no_idle = 1'b0;
    logic [ID_W-1:0]       id_pool [POOL_SIZE];
    logic [ACTIVE_W-1:0]   phase_active [PHASES];

    cit_req_if req_ch ();
    cit_rsp_if rsp_ch ();

    connection_id_table dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    connection_id_table_checker table_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (psel && penable && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("connection_id_table_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // response side: random stall before each transaction
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.func          <= func;
        req_ch.connection_id <= id;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic apb_transfer(input logic write, input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_active(input logic [ACTIVE_W-1:0] value);
        wait_idle();
        apb_transfer(1'b1, ACTIVE_ADDR, APB_DATA_W'(value));
        apb_transfer(1'b0, ACTIVE_ADDR, '0);
    endtask

    task automatic random_phase(input int count);
        int                pick;
        int                add_pct;
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   id;
        no_idle = ($urandom_range(0, 3) == 0);
        add_pct = $urandom_range(30, 55);
        for (int k = 0; k < POOL_SIZE; k++)
            id_pool[k] = ID_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 1))
        begin
            id_pool[0] = '0;
            id_pool[1] = '1;
        end
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < add_pct)
                func = FUNC_ADD;
            else if (pick < add_pct + 30)
                func = FUNC_REMOVE;
            else if (pick < 96)
                func = FUNC_CHECK;
            else
                func = FUNC_UNUSED;
            if ($urandom_range(0, 9) < 8)
                id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                id = ID_W'($urandom_range(0, 65535));
            send_item(func, id);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.func          = FUNC_ADD;
        req_ch.connection_id = '0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset value readback, then directed cases on a full-size table
        apb_transfer(1'b0, ACTIVE_ADDR, '0);
        send_item(FUNC_CHECK, 16'h0000);
        send_item(FUNC_REMOVE, 16'hffff);
        send_item(FUNC_ADD, 16'h0000);
        send_item(FUNC_ADD, 16'hffff);
        send_item(FUNC_ADD, 16'hffff);
        send_item(FUNC_CHECK, 16'hffff);
        send_item(FUNC_REMOVE, 16'h0000);
        send_item(FUNC_ADD, 16'h5555);
        send_item(FUNC_UNUSED, 16'haaaa);
        for (int k = 1; k <= 6; k++)
            send_item(FUNC_ADD, 16'h1000 + 16'(k));
        send_item(FUNC_ADD, 16'haaaa);
        send_item(FUNC_CHECK, 16'haaaa);
        send_item(FUNC_REMOVE, 16'hffff);
        send_item(FUNC_ADD, 16'haaaa);

        // unmapped register, then no active slots, then an oversized range
        wait_idle();
        apb_transfer(1'b1, UNUSED_ADDR, 32'd1);
        set_active(4'd0);
        send_item(FUNC_ADD, 16'h0001);
        send_item(FUNC_CHECK, 16'h5555);
        send_item(FUNC_REMOVE, 16'h5555);
        set_active(4'd15);
        send_item(FUNC_CHECK, 16'h1006);
        send_item(FUNC_REMOVE, 16'h1006);

        phase_active = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd5, 4'd8, 4'd2,
                         ACTIVE_W'($urandom_range(1, 8)), ACTIVE_W'($urandom_range(1, 8))};
        for (int p = 0; p < PHASES; p++)
        begin
            set_active(phase_active[p]);
            random_phase((phase_active[p] == 0) ? 20 : 100);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("connection_id_table_tb passed");
        else
            $display("connection_id_table_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
